/* rtl/eht_pkg.sv */
// shared constants for the extendible hash table unit
package eht_pkg;

  // fixed field widths
  localparam int KEY_W     = 32;
  localparam int HASH_W    = 10;
  localparam int DEPTH_W   = 4;
  localparam int STATUS_W  = 2;

  // directory is indexed by the hash, so its depth follows the hash width
  localparam int MAX_DEPTH = HASH_W;
  localparam int DIR_DEPTH = 1 << MAX_DEPTH;

  // default table geometry
  localparam int DEF_BUCKET_SLOTS = 4;
  localparam int DEF_NUM_BUCKETS  = 256;

  // request kinds
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

endpackage

/* rtl/eht_ram.sv */
// simple dual-port synchronous ram with registered read data
module eht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

/* rtl/extendible_hash_table_unit.sv */
// top level of the extendible hash table: request sequencer and table memories
//
// Requests arrive on the s_axis channel: tuser carries the kind (insert or
// search), tdata the key and its precomputed hash. Each request gives one
// result on the m_axis channel: directory slot, status and global depth.
// Requests are handled one at a time; s_axis_tready_o is high only while the
// sequencer is idle. A request can be taken while the previous result still
// waits in the output register. The sequencer steps are:
//   insert into a bucket with room, or search of an empty bucket: look up
//   the directory, read the bucket info, decide, then output the result
//   search: read and compare the filled entries one by one until a match
//   a full bucket is split: walk the directory to repoint entries, move
//   the entries, update the info of both buckets and look the bucket up
//   again; a doubling first copies the lower directory half into the upper
// Each memory has a single read port: directory walks and entry moves take
// a read step and a write step per entry, the search a read and a check.
// After reset the table is empty with global depth zero; no clearing pass
// is needed, the memories are used only where they were written. When the
// receiver stalls, the result holds in the output register and the
// sequencer waits in its output step once the next result is ready.
module extendible_hash_table_unit #(
  parameter int BUCKET_SLOTS = eht_pkg::DEF_BUCKET_SLOTS,
  parameter int NUM_BUCKETS  = eht_pkg::DEF_NUM_BUCKETS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // key [31:0], key_hash [41:32], zero [47:42]
  input  logic [47:0] s_axis_tdata_i,
  // func [0]
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // slot_index [9:0], status [11:10], depth_now [15:12]
  output logic [15:0] m_axis_tdata_o
);

  localparam int HW   = eht_pkg::HASH_W;
  localparam int KW   = eht_pkg::KEY_W;
  localparam int DW   = eht_pkg::DEPTH_W;
  localparam int SW   = eht_pkg::STATUS_W;
  localparam int DAW  = eht_pkg::MAX_DEPTH;
  localparam int BW   = $clog2(NUM_BUCKETS);
  localparam int FW   = $clog2(BUCKET_SLOTS + 1);
  localparam int SAW  = $clog2(NUM_BUCKETS * BUCKET_SLOTS);
  localparam int IW   = DAW + 1;
  localparam int INFW = DW + FW;

  // sequencer states
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_LOOK    = 4'd1;
  localparam logic [3:0] ST_BKT     = 4'd2;
  localparam logic [3:0] ST_DECIDE  = 4'd3;
  localparam logic [3:0] ST_DBL_RD  = 4'd4;
  localparam logic [3:0] ST_DBL_WR  = 4'd5;
  localparam logic [3:0] ST_SPL_RD  = 4'd6;
  localparam logic [3:0] ST_SPL_WR  = 4'd7;
  localparam logic [3:0] ST_MOV_RD  = 4'd8;
  localparam logic [3:0] ST_MOV_WR  = 4'd9;
  localparam logic [3:0] ST_OLD_UPD = 4'd10;
  localparam logic [3:0] ST_NEW_UPD = 4'd11;
  localparam logic [3:0] ST_SRCH_RD = 4'd12;
  localparam logic [3:0] ST_SRCH_CK = 4'd13;
  localparam logic [3:0] ST_OUT     = 4'd14;

  // slot address of entry i in bucket b
  function automatic logic [SAW-1:0] slot_addr(input logic [BW-1:0] b,
                                               input logic [FW-1:0] i);
    return SAW'(b) * SAW'(BUCKET_SLOTS) + SAW'(i);
  endfunction

  logic [3:0]    state_q, state_d;
  logic [DW-1:0] gd_q, gd_d;
  logic [BW:0]   biu_q, biu_d;
  logic          b0_valid_q, b0_valid_d;

  logic          func_q;
  logic [KW-1:0] key_q;
  logic [HW-1:0] hash_q;
  logic [BW-1:0] bkt_q, bkt_d;
  logic [DW-1:0] ld_q, ld_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [IW-1:0] dcnt_q, dcnt_d;
  logic [FW-1:0] scnt_q, scnt_d;
  logic [FW-1:0] keep_q, keep_d;
  logic [FW-1:0] nnew_q, nnew_d;

  logic [HW-1:0] res_slot_q, res_slot_d;
  logic [SW-1:0] res_status_q, res_status_d;

  logic          out_valid_q;
  logic [15:0]   out_data_q;

  // memory ports
  logic            dir_we;
  logic [DAW-1:0]  dir_waddr, dir_raddr;
  logic [BW-1:0]   dir_wdata, dir_rdata;
  logic            dir_ra0_q;
  logic            inf_we;
  logic [BW-1:0]   inf_waddr, inf_raddr;
  logic [INFW-1:0] inf_wdata, inf_rdata;
  logic            slt_we;
  logic [SAW-1:0]  slt_waddr, slt_raddr;
  logic [KW+HW-1:0] slt_wdata, slt_rdata;

  // derived values
  logic [HW-1:0]  idx;
  logic [IW-1:0]  entries;
  logic [BW-1:0]  dir_val;
  logic [DW-1:0]  cur_ld;
  logic [FW-1:0]  cur_fill;
  logic [BW-1:0]  fresh;
  logic           in_xfer;
  logic           out_free;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE);

  assign idx     = hash_q & HW'((IW'(1) << gd_q) - IW'(1));
  assign entries = IW'(1) << gd_q;
  assign fresh   = biu_q[BW-1:0];

  // directory entry zero always holds bucket zero and is never written
  assign dir_val = dir_ra0_q ? '0 : dir_rdata;

  // bucket zero reads as empty until its info is first written
  always_comb begin
    if (bkt_q == '0 && !b0_valid_q) begin
      cur_ld   = '0;
      cur_fill = '0;
    end else begin
      cur_ld   = inf_rdata[INFW-1:FW];
      cur_fill = inf_rdata[FW-1:0];
    end
  end

  // sequencer next state and memory access
  always_comb begin
    state_d      = state_q;
    gd_d         = gd_q;
    biu_d        = biu_q;
    b0_valid_d   = b0_valid_q;
    bkt_d        = bkt_q;
    ld_d         = ld_q;
    fill_d       = fill_q;
    dcnt_d       = dcnt_q;
    scnt_d       = scnt_q;
    keep_d       = keep_q;
    nnew_d       = nnew_q;
    res_slot_d   = res_slot_q;
    res_status_d = res_status_q;
    dir_we    = 1'b0;
    dir_waddr = '0;
    dir_wdata = '0;
    dir_raddr = idx;
    inf_we    = 1'b0;
    inf_waddr = bkt_q;
    inf_wdata = '0;
    inf_raddr = bkt_q;
    slt_we    = 1'b0;
    slt_waddr = '0;
    slt_wdata = '0;
    slt_raddr = slot_addr(bkt_q, scnt_q);

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_d = ST_BKT;
      end
      ST_BKT: begin
        bkt_d     = dir_val;
        inf_raddr = dir_val;
        state_d   = ST_DECIDE;
      end
      ST_DECIDE: begin
        ld_d   = cur_ld;
        fill_d = cur_fill;
        dcnt_d = '0;
        scnt_d = '0;
        if (func_q == eht_pkg::FUNC_SEARCH) begin
          if (cur_fill == '0) begin
            res_status_d = eht_pkg::STATUS_MISSING;
            res_slot_d   = '0;
            state_d      = ST_OUT;
          end else begin
            state_d = ST_SRCH_RD;
          end
        end else if (cur_fill < FW'(BUCKET_SLOTS)) begin
          // room in the bucket: store and bump the fill
          slt_we       = 1'b1;
          slt_waddr    = slot_addr(bkt_q, cur_fill);
          slt_wdata    = {hash_q, key_q};
          inf_we       = 1'b1;
          inf_wdata    = {cur_ld, cur_fill + FW'(1)};
          if (bkt_q == '0) begin
            b0_valid_d = 1'b1;
          end
          res_status_d = eht_pkg::STATUS_OK;
          res_slot_d   = idx;
          state_d      = ST_OUT;
        end else if ((cur_ld >= gd_q && gd_q >= DW'(eht_pkg::MAX_DEPTH)) ||
                     (biu_q >= (BW + 1)'(NUM_BUCKETS))) begin
          res_status_d = eht_pkg::STATUS_FULL;
          res_slot_d   = '0;
          state_d      = ST_OUT;
        end else if (cur_ld >= gd_q) begin
          state_d = ST_DBL_RD;
        end else begin
          state_d = ST_SPL_RD;
        end
      end
      // directory doubling: copy the lower half into the upper half
      ST_DBL_RD: begin
        dir_raddr = dcnt_q[DAW-1:0];
        state_d   = ST_DBL_WR;
      end
      ST_DBL_WR: begin
        dir_we    = 1'b1;
        dir_waddr = DAW'(entries + dcnt_q);
        dir_wdata = dir_val;
        dcnt_d    = dcnt_q + IW'(1);
        if (dcnt_q + IW'(1) == entries) begin
          gd_d    = gd_q + DW'(1);
          dcnt_d  = '0;
          state_d = ST_SPL_RD;
        end else begin
          state_d = ST_DBL_RD;
        end
      end
      // split: repoint every matching directory entry to the new bucket
      ST_SPL_RD: begin
        dir_raddr = dcnt_q[DAW-1:0];
        state_d   = ST_SPL_WR;
      end
      ST_SPL_WR: begin
        if (dir_val == bkt_q && dcnt_q[ld_q] == 1'b1) begin
          dir_we    = 1'b1;
          dir_waddr = dcnt_q[DAW-1:0];
          dir_wdata = fresh;
        end
        dcnt_d = dcnt_q + IW'(1);
        if (dcnt_q + IW'(1) == entries) begin
          scnt_d  = '0;
          keep_d  = '0;
          nnew_d  = '0;
          state_d = ST_MOV_RD;
        end else begin
          state_d = ST_SPL_RD;
        end
      end
      // redistribute the stored entries by the new depth bit
      ST_MOV_RD: begin
        slt_raddr = slot_addr(bkt_q, scnt_q);
        state_d   = ST_MOV_WR;
      end
      ST_MOV_WR: begin
        slt_we    = 1'b1;
        slt_wdata = slt_rdata;
        if (slt_rdata[KW + 32'(ld_q)] == 1'b1) begin
          slt_waddr = slot_addr(fresh, nnew_q);
          nnew_d    = nnew_q + FW'(1);
        end else begin
          slt_waddr = slot_addr(bkt_q, keep_q);
          keep_d    = keep_q + FW'(1);
        end
        scnt_d = scnt_q + FW'(1);
        if (scnt_q + FW'(1) == fill_q) begin
          state_d = ST_OLD_UPD;
        end else begin
          state_d = ST_MOV_RD;
        end
      end
      ST_OLD_UPD: begin
        inf_we    = 1'b1;
        inf_waddr = bkt_q;
        inf_wdata = {ld_q + DW'(1), keep_q};
        if (bkt_q == '0) begin
          b0_valid_d = 1'b1;
        end
        state_d = ST_NEW_UPD;
      end
      ST_NEW_UPD: begin
        inf_we    = 1'b1;
        inf_waddr = fresh;
        inf_wdata = {ld_q + DW'(1), nnew_q};
        biu_d     = biu_q + (BW + 1)'(1);
        scnt_d    = '0;
        state_d   = ST_LOOK;
      end
      // search: compare the filled slots one by one
      ST_SRCH_RD: begin
        slt_raddr = slot_addr(bkt_q, scnt_q);
        state_d   = ST_SRCH_CK;
      end
      ST_SRCH_CK: begin
        if (slt_rdata[KW-1:0] == key_q) begin
          res_status_d = eht_pkg::STATUS_OK;
          res_slot_d   = idx;
          state_d      = ST_OUT;
        end else if (scnt_q + FW'(1) == fill_q) begin
          res_status_d = eht_pkg::STATUS_MISSING;
          res_slot_d   = '0;
          state_d      = ST_OUT;
        end else begin
          scnt_d  = scnt_q + FW'(1);
          state_d = ST_SRCH_RD;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      gd_q       <= '0;
      biu_q      <= (BW + 1)'(1);
      b0_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      gd_q       <= gd_d;
      biu_q      <= biu_d;
      b0_valid_q <= b0_valid_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      func_q <= s_axis_tuser_i;
      key_q  <= s_axis_tdata_i[KW-1:0];
      hash_q <= s_axis_tdata_i[KW+HW-1:KW];
    end
    bkt_q        <= bkt_d;
    ld_q         <= ld_d;
    fill_q       <= fill_d;
    dcnt_q       <= dcnt_d;
    scnt_q       <= scnt_d;
    keep_q       <= keep_d;
    nnew_q       <= nnew_d;
    res_slot_q   <= res_slot_d;
    res_status_q <= res_status_d;
    dir_ra0_q    <= (dir_raddr == '0);
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      out_data_q <= {gd_q, res_status_q, res_slot_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // directory: bucket number per slot
  eht_ram #(
    .WIDTH(BW),
    .DEPTH(eht_pkg::DIR_DEPTH)
  ) u_dir (
    .clk_i  (clk_i),
    .we_i   (dir_we),
    .waddr_i(dir_waddr),
    .wdata_i(dir_wdata),
    .raddr_i(dir_raddr),
    .rdata_o(dir_rdata)
  );

  // bucket info: local depth and fill
  eht_ram #(
    .WIDTH(INFW),
    .DEPTH(NUM_BUCKETS)
  ) u_info (
    .clk_i  (clk_i),
    .we_i   (inf_we),
    .waddr_i(inf_waddr),
    .wdata_i(inf_wdata),
    .raddr_i(inf_raddr),
    .rdata_o(inf_rdata)
  );

  // bucket slots: hash and key
  eht_ram #(
    .WIDTH(KW + HW),
    .DEPTH(NUM_BUCKETS * BUCKET_SLOTS)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (slt_we),
    .waddr_i(slt_waddr),
    .wdata_i(slt_wdata),
    .raddr_i(slt_raddr),
    .rdata_o(slt_rdata)
  );

endmodule

/* rtl/eht_checker.sv */
// port checker for the extendible hash table unit, with its bind
module eht_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);

  // a stalled result stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // a stalled result holds its data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // status is a known code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[11:10] != 2'd3)
    else $error("bad status code");

  // slot is zero unless stored or found
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[11:10] != eht_pkg::STATUS_OK
      |-> m_axis_tdata_o[9:0] == 10'd0)
    else $error("slot set on miss or full");

  // depth never exceeds the hash width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[15:12] <= 4'(eht_pkg::MAX_DEPTH))
    else $error("depth out of range");

endmodule

bind extendible_hash_table_unit eht_checker u_eht_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);

/* tb/sv/eht_checker.sv */
// transfer monitor, table predictor and result comparison for the hash table unit
`timescale 1ns / 1ps

module eht_tb_checker #(
  parameter int BUCKET_SLOTS = eht_pkg::DEF_BUCKET_SLOTS,
  parameter int NUM_BUCKETS  = eht_pkg::DEF_NUM_BUCKETS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [47:0] s_axis_tdata_i,
  input  logic        s_axis_tuser_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [15:0] m_axis_tdata_i,
  output int          error_count_o,
  output int          pending_o,
  output int          stored_count_o,
  output int          found_count_o,
  output int          missing_count_o,
  output int          full_count_o,
  output int          top_depth_o
);

  localparam int KW = eht_pkg::KEY_W;
  localparam int HW = eht_pkg::HASH_W;
  localparam int SW = eht_pkg::STATUS_W;
  localparam int DW = eht_pkg::DEPTH_W;

  // same bit order as the result tdata: slot lowest, depth highest
  typedef struct packed {
    logic [DW-1:0] depth;
    logic [SW-1:0] status;
    logic [HW-1:0] slot;
  } table_result_t;

  // shadow copy of the table
  int unsigned   gdepth;
  int unsigned   used_buckets;
  int unsigned   dir_bucket [eht_pkg::DIR_DEPTH];
  int unsigned   bkt_depth  [NUM_BUCKETS];
  int unsigned   bkt_fill   [NUM_BUCKETS];
  logic [KW-1:0] entry_key  [NUM_BUCKETS*BUCKET_SLOTS];
  logic [HW-1:0] entry_hash [NUM_BUCKETS*BUCKET_SLOTS];

  table_result_t expected_results [$];

  function automatic void clear_table();
    gdepth       = 0;
    used_buckets = 1;
    foreach (dir_bucket[i]) dir_bucket[i] = 0;
    foreach (bkt_depth[i]) begin
      bkt_depth[i] = 0;
      bkt_fill[i]  = 0;
    end
  endfunction

  // split a full bucket on hash bit (new local depth - 1)
  function automatic void split_bucket(int unsigned old);
    int unsigned fresh;
    int unsigned bitpos;
    int unsigned keep;
    int unsigned moved;
    int unsigned src;
    int unsigned dst;
    fresh = used_buckets;
    used_buckets++;
    bitpos = bkt_depth[old];
    bkt_depth[old]   = bitpos + 1;
    bkt_depth[fresh] = bitpos + 1;
    for (int unsigned i = 0; i < (1 << gdepth); i++)
      if (dir_bucket[i] == old && i[bitpos]) dir_bucket[i] = fresh;
    keep  = 0;
    moved = 0;
    for (int unsigned i = 0; i < bkt_fill[old]; i++) begin
      src = old * BUCKET_SLOTS + i;
      if (entry_hash[src][bitpos]) begin
        dst = fresh * BUCKET_SLOTS + moved;
        moved++;
      end else begin
        dst = old * BUCKET_SLOTS + keep;
        keep++;
      end
      entry_key[dst]  = entry_key[src];
      entry_hash[dst] = entry_hash[src];
    end
    bkt_fill[old]   = keep;
    bkt_fill[fresh] = moved;
  endfunction

  // insert with directory doubling and splits, retried until stored or full
  function automatic logic [SW-1:0] insert_key(logic [KW-1:0] key,
                                               logic [HW-1:0] hash,
                                               output int unsigned slot);
    int unsigned idx;
    int unsigned b;
    int unsigned pos;
    slot = 0;
    for (int guard = 0; guard < 2 * eht_pkg::MAX_DEPTH + 4; guard++) begin
      idx = hash & ((1 << gdepth) - 1);
      b   = dir_bucket[idx];
      if (bkt_fill[b] < BUCKET_SLOTS) begin
        pos = b * BUCKET_SLOTS + bkt_fill[b];
        entry_key[pos]  = key;
        entry_hash[pos] = hash;
        bkt_fill[b]++;
        slot = idx;
        return eht_pkg::STATUS_OK;
      end
      if (bkt_depth[b] >= gdepth && gdepth >= eht_pkg::MAX_DEPTH)
        return eht_pkg::STATUS_FULL;
      if (used_buckets >= NUM_BUCKETS) return eht_pkg::STATUS_FULL;
      if (bkt_depth[b] >= gdepth) begin
        for (int unsigned i = 0; i < (1 << gdepth); i++)
          dir_bucket[(1 << gdepth) + i] = dir_bucket[i];
        gdepth++;
      end
      split_bucket(b);
    end
    return eht_pkg::STATUS_FULL;
  endfunction

  function automatic table_result_t predict_result(logic func, logic [KW-1:0] key,
                                                   logic [HW-1:0] hash);
    table_result_t r;
    int unsigned   slot;
    int unsigned   b;
    slot     = 0;
    r.status = eht_pkg::STATUS_MISSING;
    if (func == eht_pkg::FUNC_INSERT) begin
      r.status = insert_key(key, hash, slot);
    end else begin
      b = dir_bucket[hash & ((1 << gdepth) - 1)];
      for (int unsigned i = 0; i < bkt_fill[b]; i++)
        if (r.status != eht_pkg::STATUS_OK &&
            entry_key[b * BUCKET_SLOTS + i] == key) begin
          r.status = eht_pkg::STATUS_OK;
          slot     = hash & ((1 << gdepth) - 1);
        end
    end
    r.slot  = (r.status == eht_pkg::STATUS_OK) ? slot[HW-1:0] : '0;
    r.depth = gdepth[DW-1:0];
    return r;
  endfunction

  // predict on request transfers, compare on result transfers
  always @(posedge clk_i or negedge rst_ni) begin
    table_result_t want;
    table_result_t got;
    if (!rst_ni) begin
      clear_table();
      expected_results.delete();
      error_count_o   <= 0;
      pending_o       <= 0;
      stored_count_o  <= 0;
      found_count_o   <= 0;
      missing_count_o <= 0;
      full_count_o    <= 0;
      top_depth_o     <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        want = predict_result(s_axis_tuser_i, s_axis_tdata_i[31:0],
                              s_axis_tdata_i[41:32]);
        expected_results.push_back(want);
        if (want.status == eht_pkg::STATUS_FULL)
          full_count_o <= full_count_o + 1;
        else if (want.status == eht_pkg::STATUS_MISSING)
          missing_count_o <= missing_count_o + 1;
        else if (s_axis_tuser_i == eht_pkg::FUNC_INSERT)
          stored_count_o <= stored_count_o + 1;
        else
          found_count_o <= found_count_o + 1;
        top_depth_o <= gdepth;
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i;
        if (expected_results.size() == 0) begin
          $display("%0t: result transfer with none expected: actual slot %0d status %0d",
                   $time, got.slot, got.status);
          $display("%0t:   actual depth %0d", $time, got.depth);
          error_count_o <= error_count_o + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch: expected slot %0d status %0d depth %0d",
                     $time, want.slot, want.status, want.depth);
            $display("%0t:   actual slot %0d status %0d depth %0d",
                     $time, got.slot, got.status, got.depth);
            error_count_o <= error_count_o + 1;
          end
        end
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

/* tb/sv/tb_top.sv */
// stimulus, clock, reset and verdict for the hash table unit testbench
`timescale 1ns / 1ps

module tb_top;

  localparam int RANDOM_ITEMS = 1030;
  localparam int KW           = eht_pkg::KEY_W;
  localparam int HW           = eht_pkg::HASH_W;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i;
  logic        s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [15:0] m_axis_tdata_o;

  int error_count;
  int pending;
  int stored_count;
  int found_count;
  int missing_count;
  int full_count;
  int top_depth;

  // long receiver hold request and whether quiet mode (no gaps, no stalls) is on
  logic hold_req;
  logic quiet_mode;

  logic [KW-1:0] known_keys   [$];
  logic [HW-1:0] known_hashes [$];

  extendible_hash_table_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  eht_tb_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .error_count_o   (error_count),
    .pending_o       (pending),
    .stored_count_o  (stored_count),
    .found_count_o   (found_count),
    .missing_count_o (missing_count),
    .full_count_o    (full_count),
    .top_depth_o     (top_depth)
  );

  // clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // run limit
  initial begin
    #50ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // one request transfer, with a random gap before it
  task automatic send_request(logic func, logic [KW-1:0] key, logic [HW-1:0] hash);
    int gap;
    gap = quiet_mode ? 0 :
          ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(0, 2));
    repeat (gap) @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = func;
    s_axis_tdata_i  = {6'b0, hash, key};
    // ready only changes at rising edges, so a high level here means a transfer
    while (!s_axis_tready_o) @(negedge clk_i);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    if (func == eht_pkg::FUNC_INSERT) begin
      known_keys.push_back(key);
      known_hashes.push_back(hash);
    end
  endtask

  // receiver: random stalls, plus one long hold on request
  initial begin
    int   hold_cnt;
    logic hold_done;
    hold_cnt  = 0;
    hold_done = 1'b0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_cnt  = 600;
        hold_done = 1'b1;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready_i = 1'b0;
      end else if (quiet_mode) begin
        m_axis_tready_i = 1'b1;
      end else if (!m_axis_tready_i) begin
        m_axis_tready_i = ($urandom_range(0, 3) != 0);
      end else if ($urandom_range(0, 7) == 0) begin
        m_axis_tready_i = 1'b0;
        repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 50) : $urandom_range(0, 3))
          @(negedge clk_i);
      end
    end
  end

  initial begin
    logic [KW-1:0] key;
    logic [HW-1:0] hash;
    int            pick;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tuser_i  = eht_pkg::FUNC_INSERT;
    s_axis_tdata_i  = '0;
    hold_req        = 1'b0;
    quiet_mode      = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty search, extreme keys, duplicates, first split
    send_request(eht_pkg::FUNC_SEARCH, 32'h0, 10'h0);
    send_request(eht_pkg::FUNC_INSERT, 32'h8000_0000, 10'h000);
    send_request(eht_pkg::FUNC_INSERT, 32'h7fff_ffff, 10'h3ff);
    send_request(eht_pkg::FUNC_INSERT, 32'h0000_0000, 10'h000);
    send_request(eht_pkg::FUNC_INSERT, 32'h0000_0000, 10'h000);
    send_request(eht_pkg::FUNC_INSERT, 32'hffff_ffff, 10'h200);
    send_request(eht_pkg::FUNC_SEARCH, 32'h8000_0000, 10'h000);
    send_request(eht_pkg::FUNC_SEARCH, 32'h7fff_ffff, 10'h3ff);
    send_request(eht_pkg::FUNC_SEARCH, 32'h0000_0000, 10'h000);
    send_request(eht_pkg::FUNC_SEARCH, 32'hffff_ffff, 10'h200);
    send_request(eht_pkg::FUNC_SEARCH, 32'h7fff_ffff, 10'h000);
    // six keys on one hash drive the directory to full depth and overflow
    for (int i = 0; i < 6; i++)
      send_request(eht_pkg::FUNC_INSERT, 32'h1234_5600 + i, 10'h2aa);
    send_request(eht_pkg::FUNC_SEARCH, 32'h1234_5603, 10'h2aa);
    send_request(eht_pkg::FUNC_SEARCH, 32'h1234_5605, 10'h2aa);
    send_request(eht_pkg::FUNC_SEARCH, 32'h1234_5600, 10'h3ff);

    // random: mostly inserts with spread hashes, searches of stored and unknown keys
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) quiet_mode = ($urandom_range(0, 3) == 0);
      if (n == 300) hold_req = 1'b1;
      if (n == 330) hold_req = 1'b0;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        key  = $urandom();
        hash = ($urandom_range(0, 7) == 0) ? {2'($urandom_range(0, 3)), 8'h5a} :
                                             HW'($urandom());
        send_request(eht_pkg::FUNC_INSERT, key, hash);
      end else if (pick < 9 && known_keys.size() > 0) begin
        pick = $urandom_range(0, known_keys.size() - 1);
        send_request(eht_pkg::FUNC_SEARCH, known_keys[pick], known_hashes[pick]);
      end else begin
        send_request(eht_pkg::FUNC_SEARCH, $urandom(), HW'($urandom()));
      end
    end

    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    $display("run covered %0d inserts stored, %0d searches found, %0d not found",
             stored_count, found_count, missing_count);
    $display("%0d inserts dropped on a full table, global depth reached %0d",
             full_count, top_depth);
    if (error_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
